// File: src/lmfs_pkg.sv
// lmfs_pkg: shared codes and the command record for the LED matrix frame scan unit.
// No dependencies; imported by the front classifier, command queue and back end.
package lmfs_pkg;

  // request action codes as they arrive on in_action
  localparam logic [1:0] ACT_DRAW    = 2'd0;
  localparam logic [1:0] ACT_FLIP    = 2'd1;
  localparam logic [1:0] ACT_REFRESH = 2'd2;

  // command kinds carried through the queue
  localparam logic [1:0] CMD_DRAW    = 2'd0;
  localparam logic [1:0] CMD_FLIP    = 2'd1;
  localparam logic [1:0] CMD_REFRESH = 2'd2;

  // command queue depth (power of two) and pointer width
  localparam int QDEPTH = 2;
  localparam int QPW    = 1;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] col;
    logic [4:0] row;
    logic [2:0] color;
  } cmd_t;

endpackage

// File: src/lmfs_front.sv
// lmfs_front: classifies incoming requests into queue commands, drops off-panel
// draws and unused actions. Depends on lmfs_pkg.
module lmfs_front #(
  parameter int COLUMNS       = 32,
  parameter int ROWS_PER_HALF = 8
) (
  input  logic               [1:0] action,
  input  logic signed        [6:0] pos_x,
  input  logic signed        [5:0] pos_y,
  input  logic               [7:0] pixel_color,
  output logic                     keep,
  output lmfs_pkg::cmd_t           cmd
);
  import lmfs_pkg::*;

  localparam logic [6:0] COL_LIM = 7'(COLUMNS);
  localparam logic [5:0] ROW_LIM = 6'(2 * ROWS_PER_HALF);

  logic x_on;
  logic y_on;

  assign x_on = !pos_x[6] && ({1'b0, pos_x[5:0]} < COL_LIM);
  assign y_on = !pos_y[5] && ({1'b0, pos_y[4:0]} < ROW_LIM);

  always_comb begin
    cmd.col   = pos_x[5:0];
    cmd.row   = pos_y[4:0];
    cmd.color = pixel_color[7:5];  // blue, green, red
    cmd.kind  = CMD_DRAW;
    keep      = 1'b0;
    case (action)
      ACT_DRAW: begin
        cmd.kind = CMD_DRAW;
        keep     = x_on && y_on;
      end
      ACT_FLIP: begin
        cmd.kind = CMD_FLIP;
        keep     = 1'b1;
      end
      ACT_REFRESH: begin
        cmd.kind = CMD_REFRESH;
        keep     = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

endmodule

// File: src/lmfs_cmd_fifo.sv
// lmfs_cmd_fifo: short command queue between the front classifier and the back end.
// Depends on lmfs_pkg for the command record and depth.
module lmfs_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lmfs_pkg::cmd_t din,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output lmfs_pkg::cmd_t dout
);
  import lmfs_pkg::*;

  cmd_t           mem_r [QDEPTH];
  logic [QPW-1:0] wr_ptr_r;
  logic [QPW-1:0] wr_ptr_nxt;
  logic [QPW-1:0] rd_ptr_r;
  logic [QPW-1:0] rd_ptr_nxt;
  logic [QPW:0]   cnt_r;
  logic [QPW:0]   cnt_nxt;
  logic           do_push;
  logic           do_pop;

  assign full    = (cnt_r == (QPW + 1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

`ifndef ASSERT_OFF
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("command queue popped while empty");
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    push && !full && !pop |=> !empty) else $error("pushed command lost");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QPW + 1)'(QDEPTH)) else $error("command queue count out of range");
`endif

endmodule

// File: src/lmfs_back.sv
// lmfs_back: frame store, buffer select, scan row and the column shift sequencer.
// Depends on lmfs_pkg; store is a row-wide memory with per-row valid bits.
module lmfs_back #(
  parameter int COLUMNS       = 32,
  parameter int ROWS_PER_HALF = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  lmfs_pkg::cmd_t cmd,
  output logic           cmd_pop,
  input  logic           disp_en,
  output logic           out_strobe,
  output logic [2:0]     out_row_address,
  output logic [4:0]     out_column_index,
  output logic [2:0]     out_top_color,
  output logic [2:0]     out_bottom_color,
  output logic           out_last_of_row
);
  import lmfs_pkg::*;

  localparam int CW   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int RW   = $clog2(ROWS_PER_HALF);
  localparam int FR   = 2 * ROWS_PER_HALF;   // rows per frame
  localparam int NROW = 2 * FR;              // rows in store
  localparam int AW   = $clog2(NROW);
  localparam int WW   = 3 * COLUMNS;

  localparam logic [AW-1:0] FRAME_OFS = AW'(FR);
  localparam logic [AW-1:0] HALF_OFS  = AW'(ROWS_PER_HALF);
  localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS_PER_HALF - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DRAW  = 2'd1;
  localparam logic [1:0] ST_LOAD  = 2'd2;
  localparam logic [1:0] ST_SHIFT = 2'd3;

  logic [WW-1:0]   mem [NROW];

  logic [1:0]      state_r, state_nxt;
  logic            back_sel_r, back_sel_nxt;
  logic [RW-1:0]   scan_row_r, scan_row_nxt;
  logic [NROW-1:0] valid_r, valid_nxt;
  logic [CW-1:0]   col_r, col_nxt;

  logic [RW-1:0]   prev_row_r;
  logic [AW-1:0]   wr_addr_r;
  logic [CW-1:0]   d_col_r;
  logic [2:0]      d_color_r;
  logic [WW-1:0]   rd_a_r, rd_b_r;
  logic            va_r, vb_r;
  logic [WW-1:0]   top_sh_r, bot_sh_r;

  logic [RW-1:0]   new_row;
  logic [AW-1:0]   front_base, back_base;
  logic [AW-1:0]   draw_addr, rd_a_addr, rd_b_addr;
  logic            wr_en;
  logic [WW-1:0]   wr_data;

  assign new_row    = (scan_row_r == LAST_ROW) ? '0 : scan_row_r + 1'b1;
  assign front_base = back_sel_r ? '0 : FRAME_OFS;
  assign back_base  = back_sel_r ? FRAME_OFS : '0;
  assign draw_addr  = back_base + AW'(cmd.row);
  assign rd_a_addr  = (cmd.kind == CMD_DRAW) ? draw_addr : front_base + AW'(new_row);
  assign rd_b_addr  = front_base + HALF_OFS + AW'(new_row);
  assign cmd_pop    = (state_r == ST_IDLE) && cmd_valid;
  assign wr_en      = (state_r == ST_DRAW);

  // read-modify-write of one row for a draw; an unwritten row reads as black
  always_comb begin
    wr_data = va_r ? rd_a_r : '0;
    for (int c = 0; c < COLUMNS; c++) begin
      if (CW'(c) == d_col_r) begin
        wr_data[3*c +: 3] = d_color_r;
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    back_sel_nxt = back_sel_r;
    scan_row_nxt = scan_row_r;
    valid_nxt    = valid_r;
    col_nxt      = col_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            CMD_DRAW: begin
              state_nxt = ST_DRAW;
            end
            CMD_FLIP: begin
              back_sel_nxt = !back_sel_r;
              // new back frame reads as cleared
              for (int i = 0; i < NROW; i++) begin
                if ((i >= FR) == !back_sel_r) begin
                  valid_nxt[i] = 1'b0;
                end
              end
            end
            CMD_REFRESH: begin
              scan_row_nxt = new_row;
              state_nxt    = ST_LOAD;
            end
            default: begin
            end
          endcase
        end
      end
      ST_DRAW: begin
        valid_nxt[wr_addr_r] = 1'b1;
        state_nxt            = ST_IDLE;
      end
      ST_LOAD: begin
        col_nxt   = '0;
        state_nxt = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (col_r == LAST_COL) begin
          state_nxt = ST_IDLE;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      back_sel_r <= 1'b1;
      scan_row_r <= '0;
      valid_r    <= '0;
      col_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      back_sel_r <= back_sel_nxt;
      scan_row_r <= scan_row_nxt;
      valid_r    <= valid_nxt;
      col_r      <= col_nxt;
    end
  end

  // frame store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr_r] <= wr_data;
    end
    rd_a_r <= mem[rd_a_addr];
    rd_b_r <= mem[rd_b_addr];
  end

  always_ff @(posedge clk) begin
    va_r <= valid_r[rd_a_addr];
    vb_r <= valid_r[rd_b_addr];
    if (cmd_pop) begin
      wr_addr_r  <= draw_addr;
      d_col_r    <= CW'(cmd.col);
      d_color_r  <= cmd.color;
      prev_row_r <= scan_row_r;
    end
    if (state_r == ST_LOAD) begin
      top_sh_r <= (disp_en && va_r) ? rd_a_r : '0;
      bot_sh_r <= (disp_en && vb_r) ? rd_b_r : '0;
    end else if (state_r == ST_SHIFT) begin
      top_sh_r <= top_sh_r >> 3;
      bot_sh_r <= bot_sh_r >> 3;
    end
  end

  assign out_strobe       = (state_r == ST_SHIFT);
  assign out_row_address  = 3'(prev_row_r);
  assign out_column_index = 5'(col_r);
  assign out_top_color    = top_sh_r[2:0];
  assign out_bottom_color = bot_sh_r[2:0];
  assign out_last_of_row  = out_strobe && (col_r == LAST_COL);

`ifndef ASSERT_OFF
  a_row_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last_of_row |=> !out_strobe)
    else $error("results continue past last column");
  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_of_row |=> out_strobe && col_r == $past(col_r) + 1'b1)
    else $error("column sequence broken");
  a_draw_src: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DRAW |-> $past(cmd_pop) && $past(cmd.kind) == CMD_DRAW)
    else $error("draw write without a popped draw command");
`endif

endmodule

// File: src/led_matrix_frame_scan_unit.sv
// Refresh results come out one result per cycle, one for each of the COLUMNS columns. A
// refresh runs in the back end as queue pop and memory read, shift-register load, then
// column shift; a draw as a row read-modify-write on the store port; a flip in the pop alone.
// Off-panel draws and unused actions never reach the back end.
// Results cannot be stalled. Reset (rst_n low, synchronous) clears the queue, the sequencer,
// display enable, scan row and sets back buffer 1; the store's row valid bits clear at once.
module led_matrix_frame_scan_unit #(
  parameter int COLUMNS       = 32,
  parameter int ROWS_PER_HALF = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              start,
  output logic              busy,
  input  logic        [1:0] in_action,
  input  logic signed [6:0] in_pos_x,
  input  logic signed [5:0] in_pos_y,
  input  logic        [7:0] in_pixel_color,
  // configuration
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  // result channel
  output logic              out_strobe,
  output logic        [2:0] out_row_address,
  output logic        [4:0] out_column_index,
  output logic        [2:0] out_top_color,
  output logic        [2:0] out_bottom_color,
  output logic              out_last_of_row
);
  import lmfs_pkg::*;

  logic cfg_en_r;    // display enable
  logic cfg_en_nxt;

  cmd_t front_cmd;
  cmd_t q_cmd;
  logic front_keep;
  logic q_full;
  logic q_empty;
  logic q_pop;
  logic q_push;

  // configuration register; the user must write it only while the block is idle, the block itself does not enforce this
  assign cfg_en_nxt = cfg_we ? cfg_wdata : cfg_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_en_r <= 1'b0;
    end else begin
      cfg_en_r <= cfg_en_nxt;
    end
  end

  // front: classify the request; dropped requests are accepted and vanish here
  lmfs_front #(
    .COLUMNS       (COLUMNS),
    .ROWS_PER_HALF (ROWS_PER_HALF)
  ) u_front (
    .action      (in_action),
    .pos_x       (in_pos_x),
    .pos_y       (in_pos_y),
    .pixel_color (in_pixel_color),
    .keep        (front_keep),
    .cmd         (front_cmd)
  );

  // a request is taken whenever the queue has room
  assign busy   = q_full;
  assign q_push = start && !busy && front_keep;

  lmfs_cmd_fifo u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (front_cmd),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .dout  (q_cmd)
  );

  // back: frame store and scan sequencer, runs commands in order
  lmfs_back #(
    .COLUMNS       (COLUMNS),
    .ROWS_PER_HALF (ROWS_PER_HALF)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (!q_empty),
    .cmd              (q_cmd),
    .cmd_pop          (q_pop),
    .disp_en          (cfg_en_r),
    .out_strobe       (out_strobe),
    .out_row_address  (out_row_address),
    .out_column_index (out_column_index),
    .out_top_color    (out_top_color),
    .out_bottom_color (out_bottom_color),
    .out_last_of_row  (out_last_of_row)
  );

endmodule

// File: tb/tb_led_matrix_frame_scan_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for led_matrix_frame_scan_unit: directed plan, then random phases.
// Depends on lmfs_pkg (action codes) and the unit itself; nothing else.
module tb_led_matrix_frame_scan_unit;
  import lmfs_pkg::*;

  localparam int COLS      = 32;
  localparam int HALF_ROWS = 8;
  // action 3 has no name in the package; the unit must ignore it
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // one column as it leaves the shift register
  typedef struct packed {
    logic [2:0] row_addr;
    logic [4:0] column;
    logic [2:0] top;
    logic [2:0] bottom;
    logic       last;
  } scan_beat_t;

  typedef enum logic {STEP_REQUEST, STEP_CONFIG} step_kind_t;

  // one row of the directed plan; typed_scan marks a refresh whose 32 columns
  // are written out by hand (uniform colors) instead of coming from the predictor
  typedef struct packed {
    step_kind_t kind;
    logic       enable_val;
    logic [1:0] action;
    logic [6:0] x;
    logic [5:0] y;
    logic [7:0] color;
    logic       typed_scan;
    logic [2:0] typed_row;
    logic [2:0] typed_top;
    logic [2:0] typed_bottom;
  } plan_step_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic        [1:0] in_action;
  logic signed [6:0] in_pos_x;
  logic signed [5:0] in_pos_y;
  logic        [7:0] in_pixel_color;
  logic              cfg_we;
  logic              cfg_wdata;
  logic              out_strobe;
  logic        [2:0] out_row_address;
  logic        [4:0] out_column_index;
  logic        [2:0] out_top_color;
  logic        [2:0] out_bottom_color;
  logic              out_last_of_row;

  // shadow copy of the unit: both frames, back pointer, scan row, enable
  logic [2:0] shadow_frames [0:1][0:2*HALF_ROWS-1][0:COLS-1];
  logic       shadow_back;
  int         shadow_row;
  logic       shadow_enable;

  scan_beat_t row_burst[$];        // columns produced by the last predicted request
  scan_beat_t expected_beats[$];   // columns still owed by the unit, oldest first
  plan_step_t plan[$];
  int         idle_pct;
  int         fail_count;

  led_matrix_frame_scan_unit #(
    .COLUMNS       (COLS),
    .ROWS_PER_HALF (HALF_ROWS)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_pixel_color   (in_pixel_color),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_strobe       (out_strobe),
    .out_row_address  (out_row_address),
    .out_column_index (out_column_index),
    .out_top_color    (out_top_color),
    .out_bottom_color (out_bottom_color),
    .out_last_of_row  (out_last_of_row)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Applies one accepted request to the shadow state; a refresh leaves its
  // columns in row_burst for the caller to queue.
  function automatic void predict_request(logic [1:0] action, logic signed [6:0] x,
                                          logic signed [5:0] y, logic [7:0] color);
    scan_beat_t beat;
    int         addr;
    logic       front;
    row_burst.delete();
    case (action)
      ACT_DRAW: begin
        // off-panel coordinates leave the store alone; only B,G,R survive
        if (x >= 0 && x < COLS && y >= 0 && y < 2 * HALF_ROWS)
          shadow_frames[shadow_back][y][x] = color[7:5];
      end
      ACT_FLIP: begin
        shadow_back = ~shadow_back;
        for (int r = 0; r < 2 * HALF_ROWS; r++)
          for (int c = 0; c < COLS; c++)
            shadow_frames[shadow_back][r][c] = 3'd0;
      end
      ACT_REFRESH: begin
        shadow_row = (shadow_row + 1 >= HALF_ROWS) ? 0 : shadow_row + 1;
        // latch is one row behind the scan
        addr  = (shadow_row + HALF_ROWS - 1) % HALF_ROWS;
        front = ~shadow_back;
        for (int c = 0; c < COLS; c++) begin
          beat.row_addr = addr[2:0];
          beat.column   = c[4:0];
          beat.top      = shadow_enable ? shadow_frames[front][shadow_row][c] : 3'd0;
          beat.bottom   = shadow_enable ?
                          shadow_frames[front][shadow_row + HALF_ROWS][c] : 3'd0;
          beat.last     = (c == COLS - 1);
          row_burst.push_back(beat);
        end
      end
      default: ;  // unused action: no state change, no output
    endcase
  endfunction

  function automatic plan_step_t plan_req(logic [1:0] action, int x, int y, int color);
    plan_step_t s;
    s            = '0;
    s.kind       = STEP_REQUEST;
    s.action     = action;
    s.x          = x[6:0];
    s.y          = y[5:0];
    s.color      = color[7:0];
    return s;
  endfunction

  function automatic plan_step_t plan_cfg(logic enable_val);
    plan_step_t s;
    s            = '0;
    s.kind       = STEP_CONFIG;
    s.enable_val = enable_val;
    return s;
  endfunction

  // refresh whose whole row is known by inspection
  function automatic plan_step_t plan_scan(int row, int top, int bottom);
    plan_step_t s;
    s              = plan_req(ACT_REFRESH, 0, 0, 0);
    s.typed_scan   = 1'b1;
    s.typed_row    = row[2:0];
    s.typed_top    = top[2:0];
    s.typed_bottom = bottom[2:0];
    return s;
  endfunction

  function automatic void log_mismatch(string what, scan_beat_t want, scan_beat_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t %s: expected row %0d col %0d top %0d bot %0d last %0d,",
               $realtime, what, want.row_addr, want.column, want.top, want.bottom,
               want.last);
      $display("  got row %0d col %0d top %0d bot %0d last %0d",
               got.row_addr, got.column, got.top, got.bottom, got.last);
    end
  endfunction

  // Holds start high until the unit takes the request. The sender may first
  // sit idle, at the rate set for the current phase.
  task automatic issue_request(logic [1:0] action, logic [6:0] x, logic [5:0] y,
                               logic [7:0] color);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start          <= 1'b1;
    in_action      <= action;
    in_pos_x       <= x;
    in_pos_y       <= y;
    in_pixel_color <= color;
    // busy is read as it stood before this edge: low means the request went in
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    predict_request(action, x, y, color);
  endtask

  // Drops start, waits until every owed column has shown up, then lets any
  // trailing draw or flip work through the two-deep queue before the register
  // is touched.
  task automatic wait_quiet();
    start <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (COLS + 8) @(posedge clk);
  endtask

  task automatic write_enable(logic value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we        <= 1'b0;
    shadow_enable = value;
  endtask

  // Mostly on-panel draws with a flip now and then so scanned rows carry
  // content; the rest is refreshes, off-panel draws and the unused action.
  task automatic random_request();
    int          pick;
    logic [1:0]  action;
    logic [6:0]  x;
    logic [5:0]  y;
    logic [7:0]  color;
    pick  = $urandom_range(99);
    x     = 7'($urandom_range(COLS - 1));
    y     = 6'($urandom_range(2 * HALF_ROWS - 1));
    color = 8'($urandom);
    if (pick < 58) begin
      action = ACT_DRAW;
    end else if (pick < 68) begin
      action = ACT_DRAW;
      x      = 7'($urandom);
      y      = 6'($urandom);
    end else if (pick < 76) begin
      action = ACT_FLIP;
    end else if (pick < 95) begin
      action = ACT_REFRESH;
    end else begin
      action = ACT_UNUSED;
      x      = 7'($urandom);
      y      = 6'($urandom);
    end
    issue_request(action, x, y, color);
    foreach (row_burst[i]) expected_beats.push_back(row_burst[i]);
  endtask

  // Result checker: every strobe must match the oldest owed column.
  always @(posedge clk) begin
    scan_beat_t got;
    scan_beat_t want;
    if (rst_n && out_strobe) begin
      got.row_addr = out_row_address;
      got.column   = out_column_index;
      got.top      = out_top_color;
      got.bottom   = out_bottom_color;
      got.last     = out_last_of_row;
      if (expected_beats.size() == 0) begin
        log_mismatch("result with nothing owed", '0, got);
      end else begin
        want = expected_beats.pop_front();
        if (got !== want) log_mismatch("column mismatch", want, got);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    plan_step_t s;
    scan_beat_t beat;
    fail_count     = 0;
    idle_pct       = 0;
    shadow_back    = 1'b1;
    shadow_row     = 0;
    shadow_enable  = 1'b0;
    for (int f = 0; f < 2; f++)
      for (int r = 0; r < 2 * HALF_ROWS; r++)
        for (int c = 0; c < COLS; c++)
          shadow_frames[f][r][c] = 3'd0;

    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_action      <= ACT_DRAW;
    in_pos_x       <= '0;
    in_pos_y       <= '0;
    in_pixel_color <= '0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed plan. Draws land in frame 1 (back after reset); the first flip
    // shows them. Row 9 gets the single-color pixels, row 1 one with only ignored color bits,
    // row 15 column 31 the last column, and row 0 column 0 the first.
    plan.push_back(plan_cfg(1'b1));
    plan.push_back(plan_scan(0, 0, 0));                    // blank store right after reset
    plan.push_back(plan_req(ACT_DRAW, 0, 0, 8'hFF));
    plan.push_back(plan_req(ACT_DRAW, 31, 15, 8'hE0));
    plan.push_back(plan_req(ACT_DRAW, -64, 0, 8'hFF));     // off panel, most negative x
    plan.push_back(plan_req(ACT_DRAW, 63, 31, 8'hFF));     // off panel, largest x and y
    plan.push_back(plan_req(ACT_DRAW, 32, 0, 8'hFF));      // one past the last column
    plan.push_back(plan_req(ACT_DRAW, 0, 16, 8'hFF));      // one past the last row
    plan.push_back(plan_req(ACT_DRAW, 5, -32, 8'hFF));     // most negative y
    plan.push_back(plan_req(ACT_DRAW, 1, 1, 8'h1F));       // only ignored color bits set
    plan.push_back(plan_req(ACT_DRAW, 2, 9, 8'h20));       // red
    plan.push_back(plan_req(ACT_DRAW, 3, 9, 8'h40));       // green
    plan.push_back(plan_req(ACT_DRAW, 4, 9, 8'h80));       // blue
    plan.push_back(plan_req(ACT_UNUSED, 6, 1, 8'hFF));
    plan.push_back(plan_req(ACT_FLIP, 0, 0, 0));
    for (int r = 0; r < 7; r++)                            // rows 2..7, then wrap to 0
      plan.push_back(plan_req(ACT_REFRESH, 0, 0, 0));
    plan.push_back(plan_cfg(1'b0));
    plan.push_back(plan_scan(0, 0, 0));                    // row 1 has pixels, display off
    plan.push_back(plan_cfg(1'b1));
    plan.push_back(plan_req(ACT_FLIP, 0, 0, 0));           // frame 0 was cleared by first flip
    plan.push_back(plan_scan(1, 0, 0));

    foreach (plan[i]) begin
      s = plan[i];
      if (s.kind == STEP_CONFIG) begin
        wait_quiet();
        write_enable(s.enable_val);
      end else begin
        issue_request(s.action, s.x, s.y, s.color);
        if (s.typed_scan) begin
          for (int c = 0; c < COLS; c++) begin
            beat.row_addr = s.typed_row;
            beat.column   = c[4:0];
            beat.top      = s.typed_top;
            beat.bottom   = s.typed_bottom;
            beat.last     = (c == COLS - 1);
            expected_beats.push_back(beat);
          end
        end else begin
          foreach (row_burst[k]) expected_beats.push_back(row_burst[k]);
        end
      end
    end

    // Random phases: back-to-back requests, a mostly idle sender, a sometimes
    // idle sender. The middle phase runs with the display off.
    for (int ph = 0; ph < 3; ph++) begin
      wait_quiet();
      write_enable(ph != 1);
      idle_pct = (ph == 1) ? 87 : (ph == 2) ? 34 : 0;
      repeat (80) random_request();
    end

    wait_quiet();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/lmfs_pkg.sv
src/lmfs_front.sv
src/lmfs_cmd_fifo.sv
src/lmfs_back.sv
src/led_matrix_frame_scan_unit.sv
tb/tb_led_matrix_frame_scan_unit.sv
